// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Compiled out when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BNFA_ASSERT(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("allocator check failed");
`define BNFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("allocator check failed");
`define BNFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("allocator check failed");
`else
`define BNFA_ASSERT(lbl, clk, rstn, cond)
`define BNFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BNFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/bnfa_pkg.sv =====
// Shared types and constants for the bitmap next-fit allocator.
// No dependencies.
`default_nettype none
package bnfa_pkg;
	localparam int IDX_W    = 16;
	localparam int ALLOC_W  = 12;
	localparam int STATUS_W = 3;
	localparam int FREE_W   = 13;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INCONSISTENT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

	localparam logic [7:0] BYTE_MSB = 8'h80;

	// result of examining one bitmap byte
	typedef struct packed {
		logic       found;
		logic [2:0] pos;   // 0 is the MSB, i.e. the first block of the byte
	} scan_res_t;
endpackage
`default_nettype wire

// ===== rtl/bnfa_bitmap_ram.sv =====
// Occupancy bitmap store: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module bnfa_bitmap_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/bnfa_byte_scan.sv =====
// Byte examiner: finds the first free block in one bitmap byte, MSB first.
// Uses bnfa_pkg; bits past the last block of a partial final byte count as used.
`default_nettype none
module bnfa_byte_scan
	import bnfa_pkg::*;
#(
	parameter int BLOCK_COUNT = 4096,
	parameter int AW          = 9
) (
	input  wire logic [7:0]    byte_data,
	input  wire logic [AW-1:0] byte_addr,
	output scan_res_t          res
);
	localparam int MAP_BYTES = (BLOCK_COUNT + 7) / 8;
	localparam int TAIL      = BLOCK_COUNT % 8;

	logic last_byte;
	logic [7:0] avail;

	assign last_byte = (byte_addr == AW'(MAP_BYTES - 1));

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			avail[b] = !byte_data[7-b] && !(TAIL != 0 && last_byte && b >= TAIL);
		end
		res = '0;
		for (int b = 7; b >= 0; b--) begin
			if (avail[b]) begin
				res.found = 1'b1;
				res.pos   = 3'(b);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bitmap_next_fit_allocator.sv =====
// Top level of the bitmap next-fit block allocator: sequencer, counters, cursor.
// Depends on bnfa_pkg, bnfa_bitmap_ram, bnfa_byte_scan and assert_macros.svh.
//
//  channel | handshake            | beat fields
//  --------+----------------------+---------------------------------------
//  cmd     | cmd_valid, cmd_stall | command, block_index
//  rsp     | rsp_valid, rsp_stall | allocated_index, status, free_blocks
//
// Allocate runs S_IDLE, S_SCAN and S_FINISH; the scan reads k bytes from the cursor
// (1 up to (BLOCK_COUNT+7)/8), one byte per cycle through the single RAM read port.
// Free runs S_IDLE, S_FREE_CHK, S_FINISH; an out-of-range free and an allocate
// with the count at zero go from S_IDLE straight to S_FINISH. After reset the
// bitmap is cleared one byte a cycle, with cmd_stall high throughout.
// A waiting response only holds the sequencer in its final step; the next
// command is taken as soon as that response has gone.
`default_nettype none
`include "assert_macros.svh"
module bitmap_next_fit_allocator
	import bnfa_pkg::*;
#(
	parameter int BLOCK_COUNT = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic               command,
	input  wire logic [IDX_W-1:0]   block_index,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [ALLOC_W-1:0]      allocated_index,
	output logic [STATUS_W-1:0]     status,
	output logic [FREE_W-1:0]       free_blocks
);
	localparam int MAP_BYTES = (BLOCK_COUNT + 7) / 8;
	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CW        = $clog2(BLOCK_COUNT + 1);
	localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_FINISH
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         addr_q;      // byte under examination / clear sweep
	logic [AW-1:0]         seen_q;      // bytes already rejected in this scan
	logic [AW-1:0]         cursor_q;    // byte of the last grant
	logic [2:0]            bit_q;
	logic [CW-1:0]         group_q;
	logic [CW-1:0]         mirror_q;
	logic [ALLOC_W-1:0]    res_index_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  rsp_valid_q;
	logic [ALLOC_W-1:0]    rsp_index_q;
	logic [STATUS_W-1:0]   rsp_status_q;
	logic [FREE_W-1:0]     rsp_free_q;

	logic                  we;
	logic [AW-1:0]         raddr;
	logic [7:0]            wdata;
	logic [7:0]            rdata;
	logic [AW-1:0]         next_addr;
	logic [7:0]            free_mask;
	logic                  cmd_acc;
	logic                  out_free;
	logic                  idx_in_range;
	scan_res_t             scan;

	bnfa_bitmap_ram #(.DEPTH(MAP_BYTES), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bnfa_byte_scan #(.BLOCK_COUNT(BLOCK_COUNT), .AW(AW)) u_scan (
		.byte_data (rdata),
		.byte_addr (addr_q),
		.res       (scan)
	);

	assign cmd_stall    = (state_q != S_IDLE);
	assign cmd_acc      = cmd_valid && !cmd_stall;
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign idx_in_range = ({1'b0, block_index} < 17'(BLOCK_COUNT));
	assign next_addr    = (addr_q == LAST_BYTE) ? '0 : addr_q + AW'(1);
	assign free_mask    = BYTE_MSB >> bit_q;

	always_comb begin
		raddr = addr_q;
		if (state_q == S_IDLE) begin
			raddr = (command == CMD_ALLOC) ? cursor_q : AW'(block_index >> 3);
		end else if (state_q == S_SCAN && !scan.found) begin
			raddr = next_addr;
		end
	end

	always_comb begin
		we    = 1'b0;
		wdata = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_SCAN: begin
				we    = scan.found;
				wdata = rdata | (BYTE_MSB >> scan.pos);
			end
			S_FREE_CHK: begin
				we    = ((rdata & free_mask) != '0);
				wdata = rdata & ~free_mask;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			seen_q       <= '0;
			cursor_q     <= '0;
			bit_q        <= '0;
			group_q      <= CW'(BLOCK_COUNT);
			mirror_q     <= CW'(BLOCK_COUNT);
			res_index_q  <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_index_q  <= '0;
			rsp_status_q <= ST_OK;
			rsp_free_q   <= '0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					addr_q <= next_addr;
					if (addr_q == LAST_BYTE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_acc) begin
						res_index_q  <= '0;
						seen_q       <= '0;
						bit_q        <= block_index[2:0];
						addr_q       <= raddr;
						if (command == CMD_ALLOC) begin
							if (group_q == '0) begin
								res_status_q <= ST_NONE_FREE;
								state_q      <= S_FINISH;
							end else begin
								res_status_q <= ST_OK;
								state_q      <= S_SCAN;
							end
						end else if (!idx_in_range) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_FINISH;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_FREE_CHK;
						end
					end
				end
				S_SCAN: begin
					if (scan.found) begin
						group_q     <= group_q - CW'(1);
						mirror_q    <= mirror_q - CW'(1);
						cursor_q    <= addr_q;
						res_index_q <= ALLOC_W'({addr_q, scan.pos});
						state_q     <= S_FINISH;
					end else if (seen_q == LAST_BYTE) begin
						res_status_q <= ST_INCONSISTENT;
						state_q      <= S_FINISH;
					end else begin
						seen_q <= seen_q + AW'(1);
						addr_q <= next_addr;
					end
				end
				S_FREE_CHK: begin
					if ((rdata & free_mask) == '0) begin
						res_status_q <= ST_ALREADY_FREE;
					end else begin
						group_q  <= group_q + CW'(1);
						mirror_q <= mirror_q + CW'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						rsp_index_q  <= res_index_q;
						rsp_status_q <= res_status_q;
						rsp_free_q   <= FREE_W'(group_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign allocated_index = rsp_index_q;
	assign status          = rsp_status_q;
	assign free_blocks     = rsp_free_q;

	`BNFA_ASSERT(a_counts_agree, clk, arst_n, group_q == mirror_q)
	`BNFA_ASSERT(a_count_bound, clk, arst_n, group_q <= CW'(BLOCK_COUNT))
	`BNFA_ASSERT_NEXT(a_grant_takes_one, clk, arst_n, state_q == S_SCAN && scan.found,
		group_q == $past(group_q) - CW'(1))
	`BNFA_ASSERT_IMP(a_fail_no_index, clk, arst_n, rsp_valid_q && rsp_status_q != ST_OK,
		rsp_index_q == '0)
	`BNFA_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, state_q == S_CLEAR, we && cmd_stall)
endmodule
`default_nettype wire
